>>> rtl/rdpu_pkg.sv
// ----------------------------------------------------------------------------
// rdpu_pkg
// Shared types, widths and codes for the RED drop probability unit.
// ----------------------------------------------------------------------------
package rdpu_pkg;

   // field widths
   localparam int LEN_W        = 16;   // queue length, average length
   localparam int THR_W        = 16;   // thresholds
   localparam int WEIGHT_W     = 16;   // averaging weight, Q0.16
   localparam int CNT_W        = 16;   // saturating count
   localparam int DEC_W        = 2;
   localparam int AVG_FRAC     = 16;   // fraction bits of the average
   localparam int PROB_FRAC    = 16;   // fraction bits of probabilities
   localparam int PROB_W       = PROB_FRAC + 1;

   localparam int QUEUE_BITS_DEF = 16;

   // derived datapath widths
   localparam int OFF_W        = THR_W + AVG_FRAC;        // avg - min, in region
   localparam int NUM_W        = PROB_W + OFF_W;          // maxp * offset
   localparam int CP_W         = CNT_W + PROB_W;          // count * pb

   // shared divider: quotient known to fit DIV_Q_W bits
   localparam int DIV_Q_W      = PROB_W;
   localparam int DIV_D_W      = PROB_W;
   localparam int DIVD_W       = DIV_Q_W + DIV_D_W - 1;
   localparam int DIV_CNT_W    = $clog2(DIV_Q_W);

   localparam logic [PROB_W-1:0] PROB_ONE = {1'b1, {PROB_FRAC{1'b0}}};

   // configuration port
   localparam int CSR_IDX_W    = 2;
   localparam int CSR_DATA_W   = PROB_W;

   localparam logic [CSR_IDX_W-1:0] CSR_AVG_WEIGHT      = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_THRESHOLD   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_THRESHOLD   = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_PROBABILITY = 2'd3;

   localparam logic [WEIGHT_W-1:0] AVG_WEIGHT_RST      = 16'd64;
   localparam logic [THR_W-1:0]    MIN_THRESHOLD_RST   = 16'd5;
   localparam logic [THR_W-1:0]    MAX_THRESHOLD_RST   = 16'd15;
   localparam logic [PROB_W-1:0]   MAX_PROBABILITY_RST = 17'd6554;

   // decision codes
   localparam logic [DEC_W-1:0] DEC_ENQUEUE = 2'd0;
   localparam logic [DEC_W-1:0] DEC_EARLY   = 2'd1;
   localparam logic [DEC_W-1:0] DEC_FORCED  = 2'd2;

   // stream widths
   localparam int REQ_TDATA_W  = LEN_W;
   localparam int RSP_FIELDS_W = DEC_W + 2 * PROB_W + LEN_W + CNT_W;
   localparam int RSP_TDATA_W  = ((RSP_FIELDS_W + 7) / 8) * 8;
   localparam int RSP_PAD_W    = RSP_TDATA_W - RSP_FIELDS_W;

   typedef struct packed {
      logic [WEIGHT_W-1:0] avg_weight;
      logic [THR_W-1:0]    min_threshold;
      logic [THR_W-1:0]    max_threshold;
      logic [PROB_W-1:0]   max_probability;
   } cfg_type;

   typedef struct packed {
      logic capture;
      logic diff;
      logic avg_mul;
      logic avg_upd;
      logic classify;
      logic pb_mul;
      logic pb_div;
      logic pb_load;
      logic cp_mul;
      logic den_calc;
      logic pa_check;
      logic pa_load;
      logic rsp_load;
   } cmd_type;

   typedef struct packed {
      logic region;
      logic div_done;
      logic pa_sat;
      logic out_free;
   } status_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DIFF,
      ST_AVG_MUL,
      ST_AVG_UPD,
      ST_CLASSIFY,
      ST_PB_MUL,
      ST_PB_DIV,
      ST_PB_WAIT,
      ST_CP_MUL,
      ST_DEN,
      ST_PA_CHECK,
      ST_PA_WAIT,
      ST_DONE
   } state_type;

endpackage

>>> rtl/rdpu_div.sv
// ----------------------------------------------------------------------------
// rdpu_div
// Restoring divider, one quotient bit per cycle. The caller guarantees the
// top dividend bits are below the divisor, so the quotient fits DIV_Q_W bits.
// ----------------------------------------------------------------------------
module rdpu_div
   import rdpu_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [DIVD_W-1:0]  dividend,
   input  logic [DIV_D_W-1:0] divisor,
   output logic               done,
   output logic [DIV_Q_W-1:0] quotient
);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [DIV_D_W-1:0]   rem_ff, rem_in;
   logic [DIV_Q_W-1:0]   shr_ff, shr_in;
   logic [DIV_D_W-1:0]   dsr_ff, dsr_in;

   logic [DIV_D_W:0]     trial;
   logic                 qbit;

   assign trial = {rem_ff, shr_ff[DIV_Q_W-1]};
   assign qbit  = (trial >= {1'b0, dsr_ff});

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      shr_in  = shr_ff;
      dsr_in  = dsr_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = {1'b0, dividend[DIVD_W-1:DIV_Q_W]};
         shr_in  = dividend[DIV_Q_W-1:0];
         dsr_in  = divisor;
      end else if (busy_ff) begin
         rem_in = qbit ? DIV_D_W'(trial - {1'b0, dsr_ff}) : trial[DIV_D_W-1:0];
         shr_in = {shr_ff[DIV_Q_W-2:0], qbit};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DIV_CNT_W'(DIV_Q_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      shr_ff <= shr_in;
      dsr_ff <= dsr_in;
   end

   assign done     = done_ff;
   assign quotient = shr_ff;

endmodule

>>> rtl/rdpu_ctrl.sv
// ----------------------------------------------------------------------------
// rdpu_ctrl
// Sequencer for one packet: average update, classification, then the two
// divisions between thresholds, the second skipped if the adjusted probability saturates.
// ----------------------------------------------------------------------------
module rdpu_ctrl
   import rdpu_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:     if (req_tvalid) state_in = ST_DIFF;
         ST_DIFF:     state_in = ST_AVG_MUL;
         ST_AVG_MUL:  state_in = ST_AVG_UPD;
         ST_AVG_UPD:  state_in = ST_CLASSIFY;
         ST_CLASSIFY: state_in = status.region ? ST_PB_MUL : ST_DONE;
         ST_PB_MUL:   state_in = ST_PB_DIV;
         ST_PB_DIV:   state_in = ST_PB_WAIT;
         ST_PB_WAIT:  if (status.div_done) state_in = ST_CP_MUL;
         ST_CP_MUL:   state_in = ST_DEN;
         ST_DEN:      state_in = ST_PA_CHECK;
         ST_PA_CHECK: state_in = status.pa_sat ? ST_DONE : ST_PA_WAIT;
         ST_PA_WAIT:  if (status.div_done) state_in = ST_DONE;
         ST_DONE:     if (status.out_free) state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready  = 1'b1;
            cmd.capture = req_tvalid;
         end
         ST_DIFF:     cmd.diff     = 1'b1;
         ST_AVG_MUL:  cmd.avg_mul  = 1'b1;
         ST_AVG_UPD:  cmd.avg_upd  = 1'b1;
         ST_CLASSIFY: cmd.classify = 1'b1;
         ST_PB_MUL:   cmd.pb_mul   = 1'b1;
         ST_PB_DIV:   cmd.pb_div   = 1'b1;
         ST_PB_WAIT:  cmd.pb_load  = status.div_done;
         ST_CP_MUL:   cmd.cp_mul   = 1'b1;
         ST_DEN:      cmd.den_calc = 1'b1;
         ST_PA_CHECK: cmd.pa_check = 1'b1;
         ST_PA_WAIT:  cmd.pa_load  = status.div_done;
         ST_DONE:     cmd.rsp_load = status.out_free;
         default: begin
            cmd        = '0;
            req_tready = 1'b0;
         end
      endcase
   end

endmodule

>>> rtl/rdpu_datapath.sv
// ----------------------------------------------------------------------------
// rdpu_datapath
// Average and count state, probability arithmetic, shared divider and the
// result register.
// ----------------------------------------------------------------------------
module rdpu_datapath
   import rdpu_pkg::*;
#(
   parameter int QUEUE_BITS = QUEUE_BITS_DEF
)
(
   input  logic                   clock,
   input  logic                   reset,
   input  cfg_type                cfg,
   input  logic [LEN_W-1:0]       req_queue_length,
   input  cmd_type                cmd,
   output status_type             status,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata
);

   localparam int AVG_W  = QUEUE_BITS + AVG_FRAC;
   localparam int PROD_W = AVG_W + WEIGHT_W;
   localparam int INT_W  = (QUEUE_BITS > THR_W) ? QUEUE_BITS : THR_W;
   localparam int EXT_W  = INT_W + AVG_FRAC;

   logic [QUEUE_BITS-1:0]  len_ff;
   logic [AVG_W-1:0]       diff_ff;
   logic                   up_ff;
   logic [PROD_W-1:0]      prod_ff;
   logic [AVG_W-1:0]       avg_ff, avg_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic [DEC_W-1:0]       dec_ff;
   logic [OFF_W-1:0]       off_ff;
   logic [NUM_W-1:0]       num_ff;
   logic [PROB_W-1:0]      pb_ff;
   logic [PROB_W-1:0]      pa_ff;
   logic [CP_W-1:0]        cp_ff;
   logic [PROB_W-1:0]      den_ff;
   logic                   sat_ff;
   logic                   rsp_valid_ff;
   logic [RSP_TDATA_W-1:0] rsp_data_ff;

   logic [AVG_W-1:0]       target;
   logic [AVG_W-1:0]       step;
   logic [QUEUE_BITS-1:0]  avg_int;
   logic                   below_min;
   logic                   below_max;
   logic                   region;
   logic [PROB_W-1:0]      maxp;
   logic                   pa_sat;
   logic                   div_start;
   logic [DIVD_W-1:0]      div_dividend;
   logic [DIV_D_W-1:0]     div_divisor;
   logic                   div_done;
   logic [DIV_Q_W-1:0]     div_quotient;

   assign target    = {len_ff, {AVG_FRAC{1'b0}}};
   assign step      = prod_ff[PROD_W-1:WEIGHT_W];
   assign avg_in    = up_ff ? (avg_ff + step) : (avg_ff - step);
   assign avg_int   = avg_ff[AVG_W-1:AVG_FRAC];
   assign below_min = INT_W'(avg_int) < INT_W'(cfg.min_threshold);
   assign below_max = INT_W'(avg_int) < INT_W'(cfg.max_threshold);
   assign region    = !below_min && below_max;
   assign maxp      = (cfg.max_probability > PROB_ONE) ? PROB_ONE : cfg.max_probability;
   assign count_in  = (count_ff == {CNT_W{1'b1}}) ? count_ff : count_ff + 1'b1;

   // quotient of pb<<16 / den reaches 2.0 when pb/2 >= den: saturate early
   assign pa_sat = sat_ff || (PROB_W'(pb_ff[PROB_W-1:1]) >= den_ff);

   // shared divider: pb first, then pa
   assign div_start    = cmd.pb_div || (cmd.pa_check && !pa_sat);
   assign div_dividend = cmd.pb_div ? num_ff[AVG_FRAC +: DIVD_W]
                                    : {pb_ff, {PROB_FRAC{1'b0}}};
   assign div_divisor  = cmd.pb_div ? DIV_D_W'(cfg.max_threshold - cfg.min_threshold)
                                    : den_ff;

   rdpu_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quotient)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         avg_ff       <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.avg_upd) begin
            avg_ff <= avg_in;
         end
         if (cmd.classify) begin
            count_ff <= region ? count_in : '0;
         end
         if (cmd.rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         len_ff <= QUEUE_BITS'(req_queue_length);
      end
      if (cmd.diff) begin
         up_ff   <= (target >= avg_ff);
         diff_ff <= (target >= avg_ff) ? (target - avg_ff) : (avg_ff - target);
      end
      if (cmd.avg_mul) begin
         prod_ff <= PROD_W'(cfg.avg_weight) * PROD_W'(diff_ff);
      end
      if (cmd.classify) begin
         off_ff <= OFF_W'(EXT_W'(avg_ff) - EXT_W'({cfg.min_threshold, {AVG_FRAC{1'b0}}}));
         priority if (below_min) begin
            dec_ff <= DEC_ENQUEUE;
            pb_ff  <= '0;
            pa_ff  <= '0;
         end else if (below_max) begin
            dec_ff <= DEC_EARLY;
         end else begin
            dec_ff <= DEC_FORCED;
            pb_ff  <= PROB_ONE;
            pa_ff  <= PROB_ONE;
         end
      end
      if (cmd.pb_mul) begin
         num_ff <= NUM_W'(maxp) * NUM_W'(off_ff);
      end
      if (cmd.pb_load) begin
         pb_ff <= div_quotient;
      end
      if (cmd.cp_mul) begin
         cp_ff <= CP_W'(count_ff) * CP_W'(pb_ff);
      end
      if (cmd.den_calc) begin
         sat_ff <= (cp_ff >= CP_W'(PROB_ONE));
         den_ff <= PROB_ONE - cp_ff[PROB_W-1:0];
      end
      if (cmd.pa_check && pa_sat) begin
         pa_ff <= PROB_ONE;
      end
      if (cmd.pa_load) begin
         pa_ff <= (div_quotient > PROB_ONE) ? PROB_ONE : div_quotient;
      end
      if (cmd.rsp_load) begin
         rsp_data_ff <= {{RSP_PAD_W{1'b0}}, count_ff, LEN_W'(avg_int),
                         pa_ff, pb_ff, dec_ff};
      end
   end

   assign status.region   = region;
   assign status.div_done = div_done;
   assign status.pa_sat   = pa_sat;
   assign status.out_free = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

>>> rtl/red_drop_probability_unit_top.sv
// ----------------------------------------------------------------------------
// red_drop_probability_unit_top
// RED drop probability unit: per-packet average queue update and drop
// probability calculation.
// ----------------------------------------------------------------------------
// Usage
//  - req_ channel: one transaction per packet arrival, carrying the
//    instantaneous queue length. req_tready is high only while the unit is
//    idle, so one packet is worked on at a time.
//  - rsp_ channel: one transaction per packet with the decision, base and
//    adjusted probabilities (Q1.16), integer average length and count.
//  - csr_ port: plain write, index 0 weight, 1 min, 2 max, 3 max probability.
//    Write only while no packet is in flight.
// Processing steps
//  - Below min or at/above max: result loaded after the average update and classification.
//  - Between thresholds: the result waits for two passes through the shared
//    bit-serial divider plus the multiply stages; the second pass is skipped
//    when the adjusted probability saturates.
//  - A finished result sits in the output register; the next packet is
//    accepted meanwhile and only waits at its own result load if the
//    receiver still holds rsp_tready low.
// Reset
//  - Synchronous, active high: average and count cleared, registers back
//    to their defaults, no result pending.
// ----------------------------------------------------------------------------
module red_drop_probability_unit_top
   import rdpu_pkg::*;
#(
   parameter int QUEUE_BITS = QUEUE_BITS_DEF
)
(
   input  logic                   clock,
   input  logic                   reset,

   // request stream
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,   // [15:0] queue_length

   // response stream
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // [1:0] decision, [18:2] base_probability, [35:19] adjusted_probability,
   // [51:36] average_length, [67:52] drop_count, [71:68] zero
   output logic [RSP_TDATA_W-1:0] rsp_tdata,

   // configuration writes
   input  logic                   csr_we,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   cfg_type    cfg_ff;
   cmd_type    cmd;
   status_type status;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.avg_weight      <= AVG_WEIGHT_RST;
         cfg_ff.min_threshold   <= MIN_THRESHOLD_RST;
         cfg_ff.max_threshold   <= MAX_THRESHOLD_RST;
         cfg_ff.max_probability <= MAX_PROBABILITY_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_AVG_WEIGHT:      cfg_ff.avg_weight      <= csr_wdata[WEIGHT_W-1:0];
            CSR_MIN_THRESHOLD:   cfg_ff.min_threshold   <= csr_wdata[THR_W-1:0];
            CSR_MAX_THRESHOLD:   cfg_ff.max_threshold   <= csr_wdata[THR_W-1:0];
            CSR_MAX_PROBABILITY: cfg_ff.max_probability <= csr_wdata[PROB_W-1:0];
            default:             cfg_ff <= cfg_ff;
         endcase
      end
   end

   // sequencer
   rdpu_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // arithmetic, state and result register
   rdpu_datapath #(
      .QUEUE_BITS (QUEUE_BITS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg_ff),
      .req_queue_length (req_tdata[LEN_W-1:0]),
      .cmd              (cmd),
      .status           (status),
      .rsp_tvalid       (rsp_tvalid),
      .rsp_tready       (rsp_tready),
      .rsp_tdata        (rsp_tdata)
   );

endmodule
